// ----- src/hrv_pkg.sv -----
package hrv_pkg;

  localparam int unsigned WINDOW_DEF = 64;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_NN_THR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COH_SCALE = 2'd1;

  localparam logic [CFG_DATA_W-1:0] NN_THR_RST    = 16'd50;
  localparam logic [CFG_DATA_W-1:0] COH_SCALE_RST = 16'd100;

  localparam int unsigned RR_W = 16;
  localparam logic [RR_W-1:0] RR_MAX = 16'hFFFF;

  // square root unit: 40-bit radicand, 20-bit root
  localparam int unsigned SQ_OUT_W = 20;
  localparam int unsigned SQ_IN_W  = 2 * SQ_OUT_W;

  localparam int unsigned PNN_W     = 14;
  localparam int unsigned PNN_SCALE = 10000;

  localparam int unsigned Q_W = 11;
  localparam logic [Q_W-1:0] Q_ONE  = 11'd1024;
  localparam logic [Q_W-1:0] Q_HALF = 11'd512;
  localparam logic [13:0]    Q_HIGH_LIM = 14'd4096;

  localparam logic [1:0] CLS_LOW  = 2'd0;
  localparam logic [1:0] CLS_MED  = 2'd1;
  localparam logic [1:0] CLS_HIGH = 2'd2;

endpackage

// ----- src/hrv_ram.sv -----
module hrv_ram #(
  parameter int unsigned DW    = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/hrv_mul.sv -----
// shift-add multiplier, one multiplier bit per cycle, stops when the rest is zero
module hrv_mul #(
  parameter int unsigned W = 40
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] prod_o,
  output logic           done_o
);

  logic [2*W-1:0] a_q, a_d, acc_q, acc_d;
  logic [W-1:0]   b_q, b_d;
  logic           busy_q, busy_d, done_q, done_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = {{W{1'b0}}, a_i};
      b_d    = b_i;
      acc_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        if (b_q[0]) begin
          acc_d = acc_q + a_q;
        end
        a_d = {a_q[2*W-2:0], 1'b0};
        b_d = {1'b0, b_q[W-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

// ----- src/hrv_div.sv -----
// restoring divider, one quotient bit per cycle
module hrv_div #(
  parameter int unsigned DVW = 54,
  parameter int unsigned DSW = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [DSW-1:0] divisor_i,
  output logic [DVW-1:0] quot_o,
  output logic           done_o
);

  localparam int unsigned CW = $clog2(DVW + 1);

  logic [DVW-1:0] q_q, q_d;
  logic [DSW:0]   rem_q, rem_d, rem_sh;
  logic [DSW-1:0] dv_q, dv_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           busy_q, busy_d, done_q, done_d;

  always_comb begin
    q_d    = q_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[DSW-1:0], q_q[DVW-1]};
    if (start_i) begin
      q_d    = dividend_i;
      rem_d  = '0;
      dv_d   = divisor_i;
      cnt_d  = CW'(DVW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (rem_sh >= {1'b0, dv_q}) begin
          rem_d = rem_sh - {1'b0, dv_q};
          q_d   = {q_q[DVW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          q_d   = {q_q[DVW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign quot_o = q_q;
  assign done_o = done_q;

endmodule

// ----- src/hrv_sqrt.sv -----
// digit-by-digit integer square root, one root bit per cycle, truncating
module hrv_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hrv_pkg::SQ_IN_W-1:0]  x_i,
  output logic [hrv_pkg::SQ_OUT_W-1:0] root_o,
  output logic                         done_o
);

  localparam int unsigned OW = hrv_pkg::SQ_OUT_W;
  localparam int unsigned IW = hrv_pkg::SQ_IN_W;
  localparam int unsigned RW = OW + 3;
  localparam int unsigned CW = $clog2(OW + 1);

  logic [IW-1:0] x_q, x_d;
  logic [RW-1:0] rem_q, rem_d, rem_sh, trial;
  logic [OW-1:0] root_q, root_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;

  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[RW-3:0], x_q[IW-1:IW-2]};
    trial  = {1'b0, root_q, 2'b01};
    if (start_i) begin
      x_d    = x_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CW'(OW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
        x_d   = {x_q[IW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[OW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[OW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// ----- src/hrv_window_metrics.sv -----
// Heart rate variability over the newest WINDOW RR intervals. Each request is one beat
// timestamp (ms) and yields one result: SDNN and RMSSD in 1/16 ms, pNN in 0.01 %,
// coherence and stress in Q10 and a coherence class. One request is worked at a time;
// its duration is set by the walk over the interval RAM (one entry per cycle), the
// bit-serial multiplier, the bit-serial divider (one quotient bit per cycle) and the
// bit-serial square root. A new request is taken while the previous result still waits
// at the output. Configuration writes are always taken.
module hrv_window_metrics #(
  parameter int unsigned WINDOW = hrv_pkg::WINDOW_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hrv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hrv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [31:0]                    beat_time_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           metrics_valid_o,
  output logic [6:0]                     interval_count_o,
  output logic [19:0]                    sdnn_sixteenths_o,
  output logic [19:0]                    rmssd_sixteenths_o,
  output logic [13:0]                    pnn_hundredths_o,
  output logic [10:0]                    coherence_q10_o,
  output logic [10:0]                    stress_q10_o,
  output logic [1:0]                     coherence_class_o
);

  localparam int unsigned AW   = $clog2(WINDOW);
  localparam int unsigned NW   = $clog2(WINDOW + 1);
  localparam int unsigned SW   = 16 + NW;
  localparam int unsigned SQW  = 32 + NW;
  localparam int unsigned NUMW = 32 + 2 * NW;
  localparam int unsigned MW   = SQW;
  localparam int unsigned DVW  = NUMW + 8;
  localparam int unsigned DSW  = (2 * NW > 16) ? 2 * NW : 16;
  localparam int unsigned OW   = hrv_pkg::SQ_OUT_W;
  localparam int unsigned RRW  = hrv_pkg::RR_W;
  localparam int unsigned QW   = hrv_pkg::Q_W;

  typedef enum logic [23:0] {
    S_IDLE      = 24'h000001,
    S_OLD_RD    = 24'h000002,
    S_OLD       = 24'h000004,
    S_NXT       = 24'h000008,
    S_M_OLD     = 24'h000010,
    S_M_DOLD    = 24'h000020,
    S_PREV_RD   = 24'h000040,
    S_PREV      = 24'h000080,
    S_M_DNEW    = 24'h000100,
    S_ADD       = 24'h000200,
    S_M_RR      = 24'h000400,
    S_WALK_INIT = 24'h000800,
    S_WALK      = 24'h001000,
    S_M_A       = 24'h002000,
    S_M_B       = 24'h004000,
    S_M_DEN     = 24'h008000,
    S_D_SD      = 24'h010000,
    S_Q_SD      = 24'h020000,
    S_D_RM      = 24'h040000,
    S_Q_RM      = 24'h080000,
    S_M_PNN     = 24'h100000,
    S_D_PNN     = 24'h200000,
    S_D_COH     = 24'h400000,
    S_FIN       = 24'h800000
  } state_e;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    return (i == AW'(WINDOW - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] i);
    return (i == '0) ? AW'(WINDOW - 1) : i - 1'b1;
  endfunction

  function automatic logic [RRW-1:0] abs_diff(input logic [RRW-1:0] a,
                                              input logic [RRW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  state_e state_q, state_d;
  logic   go_q, go_d;

  logic [hrv_pkg::CFG_DATA_W-1:0] thr_q, thr_d, scale_q, scale_d;

  logic [31:0]     last_q, last_d;
  logic            have_q, have_d;
  logic [AW-1:0]   w_q, w_d;
  logic [NW-1:0]   n_q, n_d;
  logic [SW-1:0]   sum_q, sum_d;
  logic [SQW-1:0]  sq_q, sq_d, dsq_q, dsq_d;
  logic [NW-1:0]   over_q, over_d;

  logic [RRW-1:0]  rr_q, rr_d, old_q, old_d, dif_q, dif_d, prev_q, prev_d;
  logic [AW-1:0]   pos_q, pos_d;
  logic [NW-1:0]   wrem_q, wrem_d;
  logic            rv_q, rv_d, hp_q, hp_d;
  logic [NUMW-1:0] a_q, a_d, b_q, b_d, num;
  logic [2*NW-1:0] den_q, den_d;
  logic [OW-1:0]   sdnn_q, sdnn_d, rmssd_q, rmssd_d;
  logic [13:0]     pnn_q, pnn_d;
  logic [QW-1:0]   coh_q, coh_d;

  logic            out_valid_q, out_valid_d, load;
  logic            o_mv_q;
  logic [6:0]      o_cnt_q;
  logic [OW-1:0]   o_sdnn_q, o_rmssd_q;
  logic [13:0]     o_pnn_q;
  logic [QW-1:0]   o_coh_q, o_stress_q;
  logic [1:0]      o_cls_q;
  logic            fin_mv;
  logic [1:0]      fin_cls;

  logic [31:0]     beat_gap;
  logic [RRW-1:0]  rr_new;
  logic [NW:0]     start_sum;
  logic [AW-1:0]   start_pos;

  logic            ram_we;
  logic [AW-1:0]   ram_raddr;
  logic [RRW-1:0]  ram_rdata;

  logic            mul_start, mul_done;
  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] mul_prod;

  logic            div_start, div_done;
  logic [DVW-1:0]  div_dvd, div_quot;
  logic [DSW-1:0]  div_dsr;

  logic            sqrt_start, sqrt_done;
  logic [OW-1:0]   sqrt_root;

  hrv_ram #(.DW(RRW), .DEPTH(WINDOW)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (w_q),
    .wdata_i (rr_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hrv_mul #(.W(MW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  hrv_div #(.DVW(DVW), .DSW(DSW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  hrv_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (hrv_pkg::SQ_IN_W'(div_quot)),
    .root_o  (sqrt_root),
    .done_o  (sqrt_done)
  );

  assign beat_gap  = beat_time_ms_i - last_q;
  assign rr_new    = (beat_gap[31:16] != '0) ? hrv_pkg::RR_MAX : beat_gap[15:0];
  assign num       = (a_q > b_q) ? a_q - b_q : '0;
  // oldest stored interval: (w + WINDOW - n) mod WINDOW
  assign start_sum = (NW+1)'(w_q) + (NW+1)'(WINDOW) - (NW+1)'(n_q);
  assign start_pos = (start_sum >= (NW+1)'(WINDOW)) ? AW'(start_sum - (NW+1)'(WINDOW))
                                                    : AW'(start_sum);

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  always_comb begin
    thr_d   = thr_q;
    scale_d = scale_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hrv_pkg::REG_NN_THR:    thr_d   = cfg_data_i;
        hrv_pkg::REG_COH_SCALE: scale_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    fin_mv = (n_q >= NW'(2));
    if (coh_q < hrv_pkg::Q_HALF) begin
      fin_cls = hrv_pkg::CLS_LOW;
    end else if ((14'(coh_q) * 14'd5) < hrv_pkg::Q_HIGH_LIM) begin
      fin_cls = hrv_pkg::CLS_MED;
    end else begin
      fin_cls = hrv_pkg::CLS_HIGH;
    end
  end

  always_comb begin
    state_d    = state_q;
    go_d       = go_q;
    last_d     = last_q;
    have_d     = have_q;
    w_d        = w_q;
    n_d        = n_q;
    sum_d      = sum_q;
    sq_d       = sq_q;
    dsq_d      = dsq_q;
    over_d     = over_q;
    rr_d       = rr_q;
    old_d      = old_q;
    dif_d      = dif_q;
    prev_d     = prev_q;
    pos_d      = pos_q;
    wrem_d     = wrem_q;
    rv_d       = 1'b0;
    hp_d       = hp_q;
    a_d        = a_q;
    b_d        = b_q;
    den_d      = den_q;
    sdnn_d     = sdnn_q;
    rmssd_d    = rmssd_q;
    pnn_d      = pnn_q;
    coh_d      = coh_q;
    load       = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = w_q;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dsr    = '0;
    sqrt_start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d = beat_time_ms_i;
          have_d = 1'b1;
          go_d   = 1'b1;
          if (have_q) begin
            rr_d = rr_new;
            if (n_q == NW'(WINDOW)) begin
              state_d = S_OLD_RD;
            end else if (n_q != '0) begin
              state_d = S_PREV_RD;
            end else begin
              state_d = S_ADD;
            end
          end else begin
            state_d = S_WALK_INIT;
          end
        end
      end
      S_OLD_RD: begin
        ram_raddr = w_q;
        state_d   = S_OLD;
      end
      S_OLD: begin
        old_d     = ram_rdata;
        ram_raddr = next_slot(w_q);
        state_d   = S_NXT;
      end
      S_NXT: begin
        dif_d   = abs_diff(old_q, ram_rdata);
        go_d    = 1'b1;
        state_d = S_M_OLD;
      end
      S_M_OLD: begin
        mul_a = MW'(old_q);
        mul_b = MW'(old_q);
        if (go_q) begin
          mul_start = 1'b1;
          go_d      = 1'b0;
        end else if (mul_done) begin
          sq_d    = sq_q - SQW'(mul_prod);
          go_d    = 1'b1;
          state_d = S_M_DOLD;
        end
      end
      S_M_DOLD: begin
        mul_a = MW'(dif_q);
        mul_b = MW'(dif_q);
        if (go_q) begin
          mul_start = 1'b1;
          go_d      = 1'b0;
        end else if (mul_done) begin
          dsq_d   = dsq_q - SQW'(mul_prod);
          sum_d   = sum_q - SW'(old_q);
          n_d     = NW'(WINDOW - 1);
          state_d = S_PREV_RD;
        end
      end
      S_PREV_RD: begin
        ram_raddr = prev_slot(w_q);
        state_d   = S_PREV;
      end
      S_PREV: begin
        dif_d   = abs_diff(rr_q, ram_rdata);
        go_d    = 1'b1;
        state_d = S_M_DNEW;
      end
      S_M_DNEW: begin
        mul_a = MW'(dif_q);
        mul_b = MW'(dif_q);
        if (go_q) begin
          mul_start = 1'b1;
          go_d      = 1'b0;
        end else if (mul_done) begin
          dsq_d   = dsq_q + SQW'(mul_prod);
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        ram_we  = 1'b1;
        sum_d   = sum_q + SW'(rr_q);
        go_d    = 1'b1;
        state_d = S_M_RR;
      end
      S_M_RR: begin
        mul_a = MW'(rr_q);
        mul_b = MW'(rr_q);
        if (go_q) begin
          mul_start = 1'b1;
          go_d      = 1'b0;
        end else if (mul_done) begin
          sq_d    = sq_q + SQW'(mul_prod);
          n_d     = n_q + 1'b1;
          w_d     = next_slot(w_q);
          state_d = S_WALK_INIT;
        end
      end
      S_WALK_INIT: begin
        over_d  = '0;
        hp_d    = 1'b0;
        pos_d   = start_pos;
        wrem_d  = n_q;
        state_d = (n_q < NW'(2)) ? S_FIN : S_WALK;
      end
      S_WALK: begin
        // reads issue one per cycle; each arriving entry is compared to the one before
        if (wrem_q != '0) begin
          ram_raddr = pos_q;
          pos_d     = next_slot(pos_q);
          wrem_d    = wrem_q - 1'b1;
          rv_d      = 1'b1;
        end
        if (rv_q) begin
          if (hp_q && (abs_diff(ram_rdata, prev_q) > thr_q)) begin
            over_d = over_q + 1'b1;
          end
          prev_d = ram_rdata;
          hp_d   = 1'b1;
        end
        if ((wrem_q == '0) && !rv_q) begin
          go_d    = 1'b1;
          state_d = S_M_A;
        end
      end
      S_M_A: begin
        mul_a = MW'(n_q);
        mul_b = sq_q;
        if (go_q) begin
          mul_start = 1'b1;
          go_d      = 1'b0;
        end else if (mul_done) begin
          a_d     = NUMW'(mul_prod);
          go_d    = 1'b1;
          state_d = S_M_B;
        end
      end
      S_M_B: begin
        mul_a = MW'(sum_q);
        mul_b = MW'(sum_q);
        if (go_q) begin
          mul_start = 1'b1;
          go_d      = 1'b0;
        end else if (mul_done) begin
          b_d     = NUMW'(mul_prod);
          go_d    = 1'b1;
          state_d = S_M_DEN;
        end
      end
      S_M_DEN: begin
        mul_a = MW'(n_q);
        mul_b = MW'(n_q);
        if (go_q) begin
          mul_start = 1'b1;
          go_d      = 1'b0;
        end else if (mul_done) begin
          den_d   = (2*NW)'(mul_prod);
          go_d    = 1'b1;
          state_d = S_D_SD;
        end
      end
      S_D_SD: begin
        div_dvd = {num, 8'h00};
        div_dsr = DSW'(den_q);
        if (go_q) begin
          div_start = 1'b1;
          go_d      = 1'b0;
        end else if (div_done) begin
          go_d    = 1'b1;
          state_d = S_Q_SD;
        end
      end
      S_Q_SD: begin
        if (go_q) begin
          sqrt_start = 1'b1;
          go_d       = 1'b0;
        end else if (sqrt_done) begin
          sdnn_d  = sqrt_root;
          go_d    = 1'b1;
          state_d = S_D_RM;
        end
      end
      S_D_RM: begin
        div_dvd = DVW'({dsq_q, 8'h00});
        div_dsr = DSW'(n_q - 1'b1);
        if (go_q) begin
          div_start = 1'b1;
          go_d      = 1'b0;
        end else if (div_done) begin
          go_d    = 1'b1;
          state_d = S_Q_RM;
        end
      end
      S_Q_RM: begin
        if (go_q) begin
          sqrt_start = 1'b1;
          go_d       = 1'b0;
        end else if (sqrt_done) begin
          rmssd_d = sqrt_root;
          go_d    = 1'b1;
          state_d = S_M_PNN;
        end
      end
      S_M_PNN: begin
        mul_a = MW'(over_q);
        mul_b = MW'(hrv_pkg::PNN_SCALE);
        if (go_q) begin
          mul_start = 1'b1;
          go_d      = 1'b0;
        end else if (mul_done) begin
          go_d    = 1'b1;
          state_d = S_D_PNN;
        end
      end
      S_D_PNN: begin
        div_dvd = DVW'(mul_prod);
        div_dsr = DSW'(n_q - 1'b1);
        if (go_q) begin
          div_start = 1'b1;
          go_d      = 1'b0;
        end else if (div_done) begin
          pnn_d   = 14'(div_quot);
          go_d    = 1'b1;
          state_d = S_D_COH;
        end
      end
      S_D_COH: begin
        div_dvd = DVW'({sdnn_q, 6'b000000});
        div_dsr = DSW'(scale_q);
        if (go_q) begin
          go_d = 1'b0;
          if (scale_q == '0) begin
            coh_d   = hrv_pkg::Q_ONE;
            state_d = S_FIN;
          end else begin
            div_start = 1'b1;
          end
        end else if (div_done) begin
          coh_d   = (div_quot > DVW'(hrv_pkg::Q_ONE)) ? hrv_pkg::Q_ONE : QW'(div_quot);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          go_d    = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      thr_q       <= hrv_pkg::NN_THR_RST;
      scale_q     <= hrv_pkg::COH_SCALE_RST;
      last_q      <= '0;
      have_q      <= 1'b0;
      w_q         <= '0;
      n_q         <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      dsq_q       <= '0;
      over_q      <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      go_q        <= go_d;
      thr_q       <= thr_d;
      scale_q     <= scale_d;
      last_q      <= last_d;
      have_q      <= have_d;
      w_q         <= w_d;
      n_q         <= n_d;
      sum_q       <= sum_d;
      sq_q        <= sq_d;
      dsq_q       <= dsq_d;
      over_q      <= over_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rr_q    <= rr_d;
    old_q   <= old_d;
    dif_q   <= dif_d;
    prev_q  <= prev_d;
    pos_q   <= pos_d;
    wrem_q  <= wrem_d;
    hp_q    <= hp_d;
    a_q     <= a_d;
    b_q     <= b_d;
    den_q   <= den_d;
    sdnn_q  <= sdnn_d;
    rmssd_q <= rmssd_d;
    pnn_q   <= pnn_d;
    coh_q   <= coh_d;
    if (load) begin
      o_mv_q     <= fin_mv;
      o_cnt_q    <= 7'(n_q);
      o_sdnn_q   <= fin_mv ? sdnn_q : '0;
      o_rmssd_q  <= fin_mv ? rmssd_q : '0;
      o_pnn_q    <= fin_mv ? pnn_q : '0;
      o_coh_q    <= fin_mv ? coh_q : '0;
      o_stress_q <= fin_mv ? (hrv_pkg::Q_ONE - coh_q) : '0;
      o_cls_q    <= fin_mv ? fin_cls : hrv_pkg::CLS_LOW;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign metrics_valid_o    = o_mv_q;
  assign interval_count_o   = o_cnt_q;
  assign sdnn_sixteenths_o  = o_sdnn_q;
  assign rmssd_sixteenths_o = o_rmssd_q;
  assign pnn_hundredths_o   = o_pnn_q;
  assign coherence_q10_o    = o_coh_q;
  assign stress_q10_o       = o_stress_q;
  assign coherence_class_o  = o_cls_q;

endmodule

// ----- sim/testbench.sv -----
module testbench;

  typedef struct packed {
    logic        mvalid;
    logic [6:0]  count;
    logic [19:0] sdnn;
    logic [19:0] rmssd;
    logic [13:0] pnn;
    logic [10:0] coh;
    logic [10:0] stress;
    logic [1:0]  cls;
  } metrics_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [hrv_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [hrv_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic [31:0] beat_time_ms_i;
  logic out_valid_o, out_stall_i;
  metrics_t got;

  hrv_window_metrics DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .beat_time_ms_i, .out_valid_o, .out_stall_i,
    .metrics_valid_o(got.mvalid), .interval_count_o(got.count),
    .sdnn_sixteenths_o(got.sdnn), .rmssd_sixteenths_o(got.rmssd),
    .pnn_hundredths_o(got.pnn), .coherence_q10_o(got.coh),
    .stress_q10_o(got.stress), .coherence_class_o(got.cls)
  );

  // predictor state
  logic [15:0] thr_ms, scale_ms;
  logic [31:0] prev_beat;
  logic        seen_beat;
  logic [15:0] rr_ring [64];
  int unsigned wr_ptr, n_rr;
  longint unsigned rr_sum, rr_sq_sum, diff_sq_sum;

  logic [31:0] beat_q [$];
  metrics_t    metrics_q [$];
  int          errors, results, sent, drv_sent;
  int          idle_pct, stall_pct;
  bit          hold_send;

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int unsigned absd(int unsigned a, int unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic metrics_t predict_beat(logic [31:0] t);
    metrics_t m;
    logic [31:0] rr;
    int unsigned old, d, pos, nxt, over;
    longint unsigned a, b, num, sd, coh;
    m = '0;
    if (seen_beat) begin
      rr = t - prev_beat;
      if (rr > 32'hFFFF) rr = 32'hFFFF;
      if (n_rr >= 64) begin
        // oldest interval and its successor difference leave the sums
        old = rr_ring[wr_ptr];
        d = absd(old, rr_ring[(wr_ptr + 1) % 64]);
        rr_sum -= old;
        rr_sq_sum -= longint'(old) * old;
        diff_sq_sum -= longint'(d) * d;
        n_rr = 63;
      end
      if (n_rr >= 1) begin
        d = absd(rr, rr_ring[(wr_ptr + 63) % 64]);
        diff_sq_sum += longint'(d) * d;
      end
      rr_ring[wr_ptr] = rr[15:0];
      rr_sum += rr;
      rr_sq_sum += longint'(rr) * rr;
      n_rr++;
      wr_ptr = (wr_ptr + 1) % 64;
    end
    prev_beat = t;
    seen_beat = 1;
    m.count = n_rr[6:0];
    if (n_rr >= 2) begin
      over = 0;
      pos = (wr_ptr + 64 - n_rr) % 64;
      for (int k = 1; k < n_rr; k++) begin
        nxt = (pos + 1) % 64;
        if (absd(rr_ring[nxt], rr_ring[pos]) > thr_ms) over++;
        pos = nxt;
      end
      a = longint'(n_rr) * rr_sq_sum;
      b = rr_sum * rr_sum;
      num = a > b ? a - b : 0;
      sd = root64((num * 256) / (longint'(n_rr) * n_rr));
      m.mvalid = 1;
      m.sdnn = sd[19:0];
      m.rmssd = 20'(root64((diff_sq_sum * 256) / (n_rr - 1)));
      m.pnn = 14'((longint'(over) * 10000) / (n_rr - 1));
      coh = scale_ms == 0 ? 1024 : (sd * 64) / scale_ms;
      if (coh > 1024) coh = 1024;
      m.coh = coh[10:0];
      m.stress = 11'(1024 - coh);
      m.cls = coh < 512 ? hrv_pkg::CLS_LOW :
              (coh * 5 < 4096 ? hrv_pkg::CLS_MED : hrv_pkg::CLS_HIGH);
    end
    return m;
  endfunction

  // driver: a request stays up until the monitor has counted it as taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || sent != drv_sent) begin
        if (beat_q.size() > 0 && !hold_send && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          beat_time_ms_i <= beat_q[0];
          drv_sent = sent;
        end else begin
          in_valid_i <= 1'b0;
          beat_time_ms_i <= $urandom;
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        metrics_q = {metrics_q, predict_beat(beat_time_ms_i)};
        void'(beat_q.pop_front());
        sent++;
      end
      if (out_valid_o && !out_stall_i) begin
        results++;
        if (metrics_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $time, got);
        end else begin
          metrics_t e;
          e = metrics_q.pop_front();
          if (e !== got) begin
            errors++;
            $display("%0t: result differs, expected %p actual %p", $time, e, got);
          end
        end
      end
    end
  end

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #400_000_000;
    $display("hrv_window_metrics: mismatch");
    $finish;
  end

  task automatic drain();
    while (beat_q.size() > 0 || metrics_q.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [hrv_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == hrv_pkg::REG_NN_THR) thr_ms = val;
    else if (idx == hrv_pkg::REG_COH_SCALE) scale_ms = val;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // beats: mostly physiological intervals, sometimes odd ones
  task automatic queue_beats(int cnt);
    logic [31:0] t;
    t = $urandom;
    for (int i = 0; i < cnt; i++) begin
      case ($urandom_range(19))
        0: t = t + $urandom;
        1: t = t;
        2: t = t + 32'h10000 + $urandom_range(5000);
        3: t = t + $urandom_range(65535);
        default: t = t + $urandom_range(600, 1200);
      endcase
      beat_q = {beat_q, t};
    end
  endtask

  initial begin
    rst_ni = 0;
    cfg_valid_i = 0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 0;
    beat_time_ms_i = '0;
    out_stall_i = 0;
    hold_send = 0;
    idle_pct = 0;
    stall_pct = 0;
    errors = 0;
    results = 0;
    sent = 0;
    drv_sent = 0;
    thr_ms = hrv_pkg::NN_THR_RST;
    scale_ms = hrv_pkg::COH_SCALE_RST;
    prev_beat = 0;
    seen_beat = 0;
    wr_ptr = 0;
    n_rr = 0;
    rr_sum = 0;
    rr_sq_sum = 0;
    diff_sq_sum = 0;
    foreach (rr_ring[i]) rr_ring[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;

    // directed: first beat, zero interval, long gap, wrap, extremes
    beat_q = '{32'h0, 32'h0, 32'd800, 32'd65535 + 32'd800, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'd400, 32'd1400, 32'd1410, 32'hFFFF_0000,
               32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd5000};
    drain();
    write_reg(hrv_pkg::REG_NN_THR, 16'd0);
    write_reg(hrv_pkg::REG_COH_SCALE, 16'd1);
    beat_q = '{32'd5300, 32'd5900, 32'd5901, 32'd7000, 32'hFFFF_F000};
    drain();
    write_reg(hrv_pkg::REG_NN_THR, 16'hFFFF);
    write_reg(hrv_pkg::REG_COH_SCALE, 16'hFFFF);
    write_reg(2'd3, 16'h1234);  // unmapped index, ignored
    beat_q = '{32'h8000_0000, 32'h8000_0300, 32'h8001_0300};
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      write_reg(hrv_pkg::REG_NN_THR, ph == 5 ? 16'hFFFF : 16'($urandom_range(0, 300)));
      write_reg(hrv_pkg::REG_COH_SCALE, ph == 6 ? 16'd1 : (ph == 7 ? 16'hFFFF :
                16'($urandom_range(1, 400))));
      queue_beats(60);
      // hold-off until the block has delivered everything
      while (beat_q.size() > 30) @(posedge clk_i);
      hold_send = 1;
      while (metrics_q.size() > 0 || in_valid_i) @(posedge clk_i);
      hold_send = 0;
      queue_beats(60);
      drain();
    end
    $display("sent %0d beats, checked %0d results over 8 idle/stall phases", sent, results);
    $display("threshold and scale swept, including extremes and window wrap");
    if (errors == 0) begin
      $display("hrv_window_metrics: match");
    end else begin
      $display("hrv_window_metrics: mismatch");
    end
    $finish;
  end
endmodule
